FILE: hdl/assert_macros.svh
// Assertion macros used by the top level to check the stitching logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: hdl/tpsi_pkg.sv
// Types, constants and the triangle shape table of the patch stitching block.
`default_nettype none

package tpsi_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [7:0] DIVS_RESET = 8'd16;
	localparam int unsigned VTX_W = 15;

	// Side codes follow the order in which a cell's triangles leave the block.
	localparam logic [1:0] SIDE_NORTH = 2'd0;
	localparam logic [1:0] SIDE_SOUTH = 2'd1;
	localparam logic [1:0] SIDE_EAST  = 2'd2;
	localparam logic [1:0] SIDE_WEST  = 2'd3;

	// Grid row and column of a vertex, relative to the cell's top-left point.
	localparam logic [1:0] ROW_TOP = 2'd0;
	localparam logic [1:0] ROW_MID = 2'd1;
	localparam logic [1:0] ROW_BOT = 2'd2;
	localparam logic [1:0] COL_LEFT  = 2'd0;
	localparam logic [1:0] COL_MID   = 2'd1;
	localparam logic [1:0] COL_RIGHT = 2'd2;

	typedef struct packed {
		logic             bad;
		logic [3:0]       stitch;
		logic [VTX_W-1:0] r0;
		logic [7:0]       w;
		logic [6:0]       j;
	} cmd_t;

	typedef struct packed {
		logic [1:0] row;
		logic [1:0] col;
	} vpos_t;

	typedef struct packed {
		vpos_t a;
		vpos_t c;
	} shape_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

	typedef struct packed {
		logic busy;
		logic finishing;
	} back_status_t;

	// Outer two vertices of one triangle; the second vertex is always the centre.
	function automatic shape_t tri_shape(input logic [1:0] side, input logic half,
	                                     input logic stitched);
		shape_t s;
		s = '0;
		case (side)
			SIDE_NORTH: begin
				if (stitched) begin
					s.a = '{ROW_TOP, COL_RIGHT}; s.c = '{ROW_TOP, COL_LEFT};
				end else if (!half) begin
					s.a = '{ROW_TOP, COL_MID};   s.c = '{ROW_TOP, COL_LEFT};
				end else begin
					s.a = '{ROW_TOP, COL_RIGHT}; s.c = '{ROW_TOP, COL_MID};
				end
			end
			SIDE_SOUTH: begin
				if (stitched) begin
					s.a = '{ROW_BOT, COL_LEFT};  s.c = '{ROW_BOT, COL_RIGHT};
				end else if (!half) begin
					s.a = '{ROW_BOT, COL_LEFT};  s.c = '{ROW_BOT, COL_MID};
				end else begin
					s.a = '{ROW_BOT, COL_MID};   s.c = '{ROW_BOT, COL_RIGHT};
				end
			end
			SIDE_EAST: begin
				if (stitched) begin
					s.a = '{ROW_BOT, COL_RIGHT}; s.c = '{ROW_TOP, COL_RIGHT};
				end else if (!half) begin
					s.a = '{ROW_MID, COL_RIGHT}; s.c = '{ROW_TOP, COL_RIGHT};
				end else begin
					s.a = '{ROW_BOT, COL_RIGHT}; s.c = '{ROW_MID, COL_RIGHT};
				end
			end
			default: begin
				if (stitched) begin
					s.a = '{ROW_TOP, COL_LEFT};  s.c = '{ROW_BOT, COL_LEFT};
				end else if (!half) begin
					s.a = '{ROW_TOP, COL_LEFT};  s.c = '{ROW_MID, COL_LEFT};
				end else begin
					s.a = '{ROW_MID, COL_LEFT};  s.c = '{ROW_BOT, COL_LEFT};
				end
			end
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

FILE: hdl/tpsi_front.sv
// Front end: classifies an incoming cell and computes its first row base.
`default_nettype none

module tpsi_front
	import tpsi_pkg::*;
(
	input  wire logic [5:0] cell_row,
	input  wire logic [5:0] cell_col,
	input  wire logic [3:0] edge_mask,
	input  wire logic [7:0] divs,
	output cmd_t            cmd
);

	logic [6:0] i;
	logic [6:0] j;
	logic [7:0] w;
	logic [7:0] edge_last;

	assign i = {cell_row, 1'b0};
	assign j = {cell_col, 1'b0};
	assign w = divs + 8'd1;
	// Wraps when divs is zero, but then every cell is already out of the grid.
	assign edge_last = divs - 8'd2;

	always_comb begin
		cmd.bad       = ({1'b0, i} >= divs) || ({1'b0, j} >= divs);
		cmd.stitch[0] = edge_mask[0] && (i == 7'd0);
		cmd.stitch[1] = edge_mask[1] && ({1'b0, i} == edge_last);
		cmd.stitch[2] = edge_mask[2] && ({1'b0, j} == edge_last);
		cmd.stitch[3] = edge_mask[3] && (j == 7'd0);
		cmd.r0        = VTX_W'(i) * VTX_W'(w);
		cmd.w         = w;
		cmd.j         = j;
	end

endmodule

`default_nettype wire

FILE: hdl/tpsi_queue.sv
// Short request queue between the front end and the triangle sequencer.
`default_nettype none

module tpsi_queue
	import tpsi_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t wdata,
	input  wire logic pop,
	output cmd_t      rdata,
	output q_status_t status
);

	cmd_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1))
			return '0;
		return p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (push && !pop)
				count_q <= count_q + QCNT_W'(1);
			else if (pop && !push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	assign rdata        = mem_q[rd_ptr_q];
	assign status.full  = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign status.valid = (count_q != '0);

endmodule

`default_nettype wire

FILE: hdl/tpsi_back.sv
// Back end: walks a cell's sides and emits one triangle per cycle while out_stall is low.
`default_nettype none

module tpsi_back
	import tpsi_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              head,
	input  wire logic              head_valid,
	output logic                   pop,
	input  wire logic              out_stall,
	output logic                   out_valid,
	output logic [VTX_W-1:0]       vertex_a,
	output logic [VTX_W-1:0]       vertex_b,
	output logic [VTX_W-1:0]       vertex_c,
	output logic                   last_of_cell,
	output logic                   bad_cell,
	output back_status_t           status
);

	logic             busy_q;
	logic             bad_q;
	logic [3:0]       stitch_q;
	logic [VTX_W-1:0] rj0_q;
	logic [VTX_W-1:0] rj1_q;
	logic [VTX_W-1:0] rj2_q;
	logic [2:0]       step_q;
	logic             out_valid_q;
	logic [VTX_W-1:0] va_q;
	logic [VTX_W-1:0] vb_q;
	logic [VTX_W-1:0] vc_q;
	logic             last_q;
	logic             bad_out_q;

	logic [1:0]       side;
	logic             half;
	logic             st;
	logic             last_now;
	logic             adv;
	logic [2:0]       next_step;
	shape_t           shape;
	logic [VTX_W-1:0] va;
	logic [VTX_W-1:0] vc;

	function automatic logic [VTX_W-1:0] pick(input vpos_t v, input logic [VTX_W-1:0] b0,
	                                          input logic [VTX_W-1:0] b1,
	                                          input logic [VTX_W-1:0] b2);
		logic [VTX_W-1:0] base;
		case (v.row)
			ROW_TOP: base = b0;
			ROW_MID: base = b1;
			default: base = b2;
		endcase
		return base + VTX_W'(v.col);
	endfunction

	assign side      = step_q[2:1];
	assign half      = step_q[0];
	assign st        = stitch_q[side];
	assign last_now  = bad_q || ((side == SIDE_WEST) && (st || half));
	// A stitched side has a single triangle, so the walk jumps to the next side.
	assign next_step = st ? {side + 2'd1, 1'b0} : step_q + 3'd1;
	assign shape     = tri_shape(side, half, st);
	assign va        = pick(shape.a, rj0_q, rj1_q, rj2_q);
	assign vc        = pick(shape.c, rj0_q, rj1_q, rj2_q);

	assign adv = busy_q && (!out_valid_q || !out_stall);
	assign pop = head_valid && (!busy_q || (adv && last_now));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (adv && last_now) begin
				busy_q <= 1'b0;
			end else if (adv) begin
				step_q <= next_step;
			end
			if (adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			bad_q    <= head.bad;
			stitch_q <= head.stitch;
			rj0_q    <= head.r0 + VTX_W'(head.j);
			rj1_q    <= head.r0 + VTX_W'(head.w) + VTX_W'(head.j);
			rj2_q    <= head.r0 + VTX_W'({head.w, 1'b0}) + VTX_W'(head.j);
		end
		if (adv) begin
			va_q      <= bad_q ? '0 : va;
			vb_q      <= bad_q ? '0 : rj1_q + VTX_W'(1);
			vc_q      <= bad_q ? '0 : vc;
			last_q    <= last_now;
			bad_out_q <= bad_q;
		end
	end

	assign out_valid        = out_valid_q;
	assign vertex_a         = va_q;
	assign vertex_b         = vb_q;
	assign vertex_c         = vc_q;
	assign last_of_cell     = last_q;
	assign bad_cell         = bad_out_q;
	assign status.busy      = busy_q;
	assign status.finishing = adv && last_now;

endmodule

`default_nettype wire

FILE: hdl/terrain_patch_stitch_indices.sv
// Top level of the terrain patch stitching index generator.
//
//  channel   direction  handshake          payload
//  in        request    in_valid/in_stall  cell_row, cell_col, edge_mask
//  out       result     out_valid/out_stall vertex_a/b/c, last_of_cell, bad_cell
//  cfg       write      cfg_valid/cfg_ready cfg_data (divisions)
//
// A cell gives 4 to 8 triangles from the back-end sequencer, one per cycle while out_stall
// is low; a cell outside the grid gives one. A request passes through the queue and the
// sequencer's cell registers before its first triangle is registered. Reset sets divisions
// to 16 and empties the queue; there is no clearing pass. The two-entry queue keeps requests
// flowing while out_stall holds the output register, and in_stall rises only when that queue is full.
`default_nettype none
`include "assert_macros.svh"

module terrain_patch_stitch_indices
	import tpsi_pkg::*;
#(
	parameter int unsigned MAX_DIVS = 128
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [5:0]        cell_row,
	input  wire logic [5:0]        cell_col,
	input  wire logic [3:0]        edge_mask,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [VTX_W-1:0]       vertex_a,
	output logic [VTX_W-1:0]       vertex_b,
	output logic [VTX_W-1:0]       vertex_c,
	output logic                   last_of_cell,
	output logic                   bad_cell,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        cfg_data
);

	localparam logic [7:0] DivCap = 8'(MAX_DIVS - MAX_DIVS % 2);

	logic [7:0]   divisions_q;
	logic [7:0]   divs_even;
	logic [7:0]   divs;
	cmd_t         front_cmd;
	cmd_t         head;
	logic         push;
	logic         pop;
	q_status_t    q_status;
	back_status_t back_status;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			divisions_q <= DIVS_RESET;
		else if (cfg_valid && cfg_ready)
			divisions_q <= cfg_data;
	end

	assign divs_even = divisions_q & 8'hFE;
	assign divs      = (divs_even > DivCap) ? DivCap : divs_even;

	assign in_stall = q_status.full;
	assign push     = in_valid && !in_stall;

	tpsi_front u_front (
		.cell_row  (cell_row),
		.cell_col  (cell_col),
		.edge_mask (edge_mask),
		.divs      (divs),
		.cmd       (front_cmd)
	);

	tpsi_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (front_cmd),
		.pop    (pop),
		.rdata  (head),
		.status (q_status)
	);

	tpsi_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (q_status.valid),
		.pop          (pop),
		.out_stall    (out_stall),
		.out_valid    (out_valid),
		.vertex_a     (vertex_a),
		.vertex_b     (vertex_b),
		.vertex_c     (vertex_c),
		.last_of_cell (last_of_cell),
		.bad_cell     (bad_cell),
		.status       (back_status)
	);

	// An out-of-grid cell gives exactly one result, all vertices zero.
	`ASSERT_CLK(a_bad_is_single, clk, arst_n, out_valid && bad_cell |-> last_of_cell && vertex_a == '0 && vertex_b == '0 && vertex_c == '0, "bad cell result malformed")
	// The sequencer may only take a request the queue actually holds.
	`ASSERT_NEVER(a_pop_empty, clk, arst_n, pop && !q_status.valid, "pop from empty queue")
	// The final triangle of a cell shows up in the next cycle with its mark.
	`ASSERT_CLK(a_finish_marked, clk, arst_n, back_status.finishing |=> out_valid && last_of_cell, "cell end not marked")
	// While a triangle that is not the last waits at the output, the sequencer still owns that cell.
	`ASSERT_CLK(a_more_pending, clk, arst_n, out_valid && !last_of_cell |-> back_status.busy, "cell ended early")

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the terrain patch stitching index generator.
`timescale 1ns / 1ps

module tb;
	import tpsi_pkg::*;

	localparam int unsigned MAX_DIVS = 128;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_PER_SETTING = 34;

	localparam logic [3:0] STITCH_NORTH = 4'b0001;
	localparam logic [3:0] STITCH_SOUTH = 4'b0010;
	localparam logic [3:0] STITCH_EAST  = 4'b0100;
	localparam logic [3:0] STITCH_WEST  = 4'b1000;

	typedef struct packed {
		logic [VTX_W-1:0] a;
		logic [VTX_W-1:0] b;
		logic [VTX_W-1:0] c;
		logic             last;
		logic             bad;
	} triangle_t;

	class stitch_predictor;
		logic [7:0]  divisions;
		triangle_t   tris_due[$];
		int unsigned errors;
		int unsigned cells;
		int unsigned tris;

		function new();
			divisions = DIVS_RESET;
			errors = 0;
			cells = 0;
			tris = 0;
		endfunction

		function int unsigned grid_divs();
			int unsigned d;
			d = divisions & 8'hFE;
			if (d > MAX_DIVS)
				d = MAX_DIVS & ~32'd1;
			return d;
		endfunction

		function void add_tri(int unsigned a, int unsigned b, int unsigned c);
			triangle_t t;
			t.a = a[VTX_W-1:0];
			t.b = b[VTX_W-1:0];
			t.c = c[VTX_W-1:0];
			t.last = 1'b0;
			t.bad = 1'b0;
			tris_due = {tris_due, t};
		endfunction

		// Expands one accepted request into the triangles it must produce.
		function void take_cell(logic [5:0] row, logic [5:0] col, logic [3:0] mask);
			int unsigned d, i, j, w, r0, r1, r2, ctr;
			triangle_t t;
			cells++;
			d = grid_divs();
			i = {row, 1'b0};
			j = {col, 1'b0};
			w = d + 1;
			if (i >= d || j >= d) begin
				t = '0;
				t.last = 1'b1;
				t.bad = 1'b1;
				tris_due = {tris_due, t};
				return;
			end
			r0 = i * w;
			r1 = (i + 1) * w;
			r2 = (i + 2) * w;
			ctr = r1 + j + 1;

			if ((mask & STITCH_NORTH) != 0 && i == 0) begin
				add_tri(r0 + j + 2, ctr, r0 + j);
			end else begin
				add_tri(r0 + j + 1, ctr, r0 + j);
				add_tri(r0 + j + 2, ctr, r0 + j + 1);
			end
			if ((mask & STITCH_SOUTH) != 0 && i == d - 2) begin
				add_tri(r2 + j, ctr, r2 + j + 2);
			end else begin
				add_tri(r2 + j, ctr, r2 + j + 1);
				add_tri(r2 + j + 1, ctr, r2 + j + 2);
			end
			if ((mask & STITCH_EAST) != 0 && j == d - 2) begin
				add_tri(r2 + j + 2, ctr, r0 + j + 2);
			end else begin
				add_tri(r1 + j + 2, ctr, r0 + j + 2);
				add_tri(r2 + j + 2, ctr, r1 + j + 2);
			end
			if ((mask & STITCH_WEST) != 0 && j == 0) begin
				add_tri(r0 + j, ctr, r2 + j);
			end else begin
				add_tri(r0 + j, ctr, r1 + j);
				add_tri(r1 + j, ctr, r2 + j);
			end
			tris_due[tris_due.size() - 1].last = 1'b1;
		endfunction

		function void compare(string field, logic [VTX_W-1:0] want, logic [VTX_W-1:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			end
		endfunction

		function void match_triangle(triangle_t got);
			triangle_t want;
			tris++;
			if (tris_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected triangle %0d %0d %0d last %0b bad %0b",
				         $time, got.a, got.b, got.c, got.last, got.bad);
				return;
			end
			want = tris_due.pop_front();
			compare("vertex_a", want.a, got.a);
			compare("vertex_b", want.b, got.b);
			compare("vertex_c", want.c, got.c);
			compare("last_of_cell", VTX_W'(want.last), VTX_W'(got.last));
			compare("bad_cell", VTX_W'(want.bad), VTX_W'(got.bad));
		endfunction
	endclass

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [5:0]       cell_row = '0;
	logic [5:0]       cell_col = '0;
	logic [3:0]       edge_mask = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [VTX_W-1:0] vertex_a;
	logic [VTX_W-1:0] vertex_b;
	logic [VTX_W-1:0] vertex_c;
	logic             last_of_cell;
	logic             bad_cell;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [7:0]       cfg_data = '0;

	stitch_predictor sb;
	int unsigned     send_idle = 0;
	int unsigned     recv_idle = 0;
	int unsigned     cycle_count = 0;
	int unsigned     settings_used = 1;

	terrain_patch_stitch_indices #(.MAX_DIVS(MAX_DIVS)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.cell_row(cell_row),
		.cell_col(cell_col),
		.edge_mask(edge_mask),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.vertex_a(vertex_a),
		.vertex_b(vertex_b),
		.vertex_c(vertex_c),
		.last_of_cell(last_of_cell),
		.bad_cell(bad_cell),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Run timed out after %0d cycles.", cycle_count);
			$display("*** FAILED ***");
			$finish;
		end
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.match_triangle('{vertex_a, vertex_b, vertex_c, last_of_cell, bad_cell});
	end

	// Called at a falling edge; returns at the falling edge after the request is taken.
	task automatic send_cell(input logic [5:0] row, input logic [5:0] col,
	                         input logic [3:0] mask);
		if (sb.cells < 150) begin
			send_idle = 34;
			recv_idle = 63;
		end else if (sb.cells < 300) begin
			send_idle = 63;
			recv_idle = 34;
		end else begin
			send_idle = 0;
			recv_idle = 0;
		end
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cell_row <= row;
		cell_col <= col;
		edge_mask <= mask;
		do
			@(posedge clk);
		while (in_stall);
		sb.take_cell(row, col, mask);
		@(negedge clk);
	endtask

	task automatic send_random_cell();
		int unsigned half;
		logic [5:0]  row, col;
		half = sb.grid_divs() / 2;
		if (half == 0 || $urandom_range(99) < 15) begin
			row = 6'($urandom);
			col = 6'($urandom);
		end else begin
			// Lean toward patch edges so that stitching gets exercised.
			if ($urandom_range(99) < 40)
				row = $urandom_range(1) ? 6'(half - 1) : 6'd0;
			else
				row = 6'($urandom_range(half - 1));
			if ($urandom_range(99) < 40)
				col = $urandom_range(1) ? 6'(half - 1) : 6'd0;
			else
				col = 6'($urandom_range(half - 1));
		end
		send_cell(row, col, 4'($urandom_range(15)));
	endtask

	task automatic write_divisions(input logic [7:0] value);
		in_valid <= 1'b0;
		while (sb.tris_due.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		sb.divisions = value;
		settings_used++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		logic [7:0] div_plan [13];
		sb = new();
		div_plan = '{8'd0, 8'd1, 8'd2, 8'd3, 8'd255, 8'd128, 8'd129, 8'd130,
		             8'd4, 8'd127, 8'd64, 8'd0, 8'd16};
		div_plan[11] = 8'($urandom_range(255));

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Corners, edges and interior of the reset grid of eight by eight cells.
		send_cell(6'd0, 6'd0, 4'd0);
		send_cell(6'd0, 6'd0, 4'd15);
		send_cell(6'd7, 6'd7, 4'd15);
		send_cell(6'd0, 6'd7, 4'd15);
		send_cell(6'd7, 6'd0, 4'd15);
		send_cell(6'd0, 6'd0, STITCH_NORTH);
		send_cell(6'd7, 6'd0, STITCH_SOUTH);
		send_cell(6'd0, 6'd7, STITCH_EAST);
		send_cell(6'd0, 6'd0, STITCH_WEST);
		send_cell(6'd3, 6'd4, 4'd15);
		send_cell(6'd7, 6'd7, 4'd0);
		send_cell(6'd0, 6'd3, STITCH_SOUTH | STITCH_EAST);
		// Cells past the last row or column.
		send_cell(6'd8, 6'd0, 4'd0);
		send_cell(6'd0, 6'd8, 4'd15);
		send_cell(6'd63, 6'd63, 4'd15);
		send_cell(6'd63, 6'd0, 4'd5);
		send_cell(6'd0, 6'd63, 4'd10);

		for (int s = 0; s < 13; s++) begin
			write_divisions(div_plan[s]);
			for (int k = 0; k < RANDOM_PER_SETTING; k++)
				send_random_cell();
		end
		in_valid <= 1'b0;

		while (sb.tris_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);

		$display("Sent %0d cells over %0d division settings, checked %0d triangles.",
		         sb.cells, settings_used, sb.tris);
		$display("Mismatches found: %0d.", sb.errors);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
